// ===== hdl/llrs_pkg.sv =====
// Shared types and constants for the location list range scanner.
package llrs_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_PC      = 2'd0,
    REG_START_BASE    = 2'd1,
    REG_ADDRESS_BYTES = 2'd2,
    REG_BIG_ENDIAN    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_MATCH = 2'd0,
    ST_END   = 2'd1,
    ST_TRUNC = 2'd2
  } status_t;

  localparam logic [3:0] ADDR_BYTES_RESET = 4'd4;
  localparam int         LEN_BYTES        = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] expr_offset;
    logic [15:0] expr_length;
    logic [63:0] range_low;
    logic [63:0] range_high;
  } out_item_t;

  typedef struct packed {
    logic [63:0] query_pc;
    logic [63:0] start_base;
    logic [3:0]  address_bytes;
    logic        big_endian;
  } cfg_regs_t;

  typedef struct packed {
    logic        load;
    logic [63:0] value;
  } base_wr_t;

endpackage

// ===== hdl/location_list_range_scanner.sv =====
// Top level of the location list range scanner: configuration registers and channels.
// Takes one list byte per cycle; each result is registered in the result buffer before it reaches the output.
// Throughput is one byte per cycle; in_ready drops only while both result slots are full.
// Each byte is parsed by the scanner combinationally; the result buffer holds two items.
// Reset sets the registers to their defaults and puts the scanner at the start of a list.
module location_list_range_scanner #(
  parameter int MAX_LIST_BYTES = 65536,
  parameter int MAX_ADDR_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  llrs_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output llrs_pkg::out_item_t               out_item,
  input  logic                              cfg_we,
  input  logic [llrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [llrs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import llrs_pkg::*;

  cfg_regs_t cfg_r;
  base_wr_t  base_wr;
  logic      accept;
  logic      res_valid;
  out_item_t res_item;
  logic      buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_pc      <= '0;
      cfg_r.start_base    <= '0;
      cfg_r.address_bytes <= ADDR_BYTES_RESET;
      cfg_r.big_endian    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUERY_PC:      cfg_r.query_pc      <= cfg_wdata;
        REG_START_BASE:    cfg_r.start_base    <= cfg_wdata;
        REG_ADDRESS_BYTES: cfg_r.address_bytes <= cfg_wdata[3:0];
        REG_BIG_ENDIAN:    cfg_r.big_endian    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign base_wr.load  = cfg_we && (cfg_index == REG_START_BASE);
  assign base_wr.value = cfg_wdata;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  llrs_scan #(
    .MAX_LIST_BYTES (MAX_LIST_BYTES),
    .MAX_ADDR_BYTES (MAX_ADDR_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .base_wr   (base_wr),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  llrs_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_item  (res_item),
    .full       (buf_full),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// ===== hdl/llrs_scan.sv =====
// Byte parser for location list entries: field assembly, rebasing and range check.
module llrs_scan #(
  parameter int MAX_LIST_BYTES = 65536,
  parameter int MAX_ADDR_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  llrs_pkg::in_item_t   in_item,
  input  llrs_pkg::cfg_regs_t  cfg,
  input  llrs_pkg::base_wr_t   base_wr,
  output logic                 res_valid,
  output llrs_pkg::out_item_t  res_item
);
  import llrs_pkg::*;

  localparam int RAW_W = 8 * MAX_ADDR_BYTES;
  localparam int CNT_W = (MAX_ADDR_BYTES > 1) ? $clog2(MAX_ADDR_BYTES) : 1;
  localparam int OFF_W = $clog2(MAX_LIST_BYTES + 1);

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_LEN  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RAW_W-1:0]   low_r, low_nxt;
  logic [RAW_W-1:0]   high_r, high_nxt;
  logic [63:0]        lo_r, lo_nxt;
  logic [63:0]        hi_r, hi_nxt;
  logic [63:0]        base_r, base_nxt;
  logic [15:0]        len_r, len_nxt;
  logic [15:0]        skip_r, skip_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic               fin_r, fin_nxt;

  logic [CNT_W:0]     aw;
  logic [CNT_W:0]     cnt_inc;
  logic [RAW_W-1:0]   mask;
  logic [RAW_W-1:0]   field_base;
  logic [RAW_W-1:0]   field_sh;
  logic [15:0]        len_base;
  logic [15:0]        len_sh;
  logic [15:0]        skip_dec;
  logic [OFF_W-1:0]   off_inc;
  logic [7:0]         b;

  // Effective address width: zero acts as one, oversize clamps to the maximum.
  always_comb begin
    if (cfg.address_bytes == 4'd0) begin
      aw = (CNT_W+1)'(1);
    end else if (cfg.address_bytes > 4'(MAX_ADDR_BYTES)) begin
      aw = (CNT_W+1)'(MAX_ADDR_BYTES);
    end else begin
      aw = (CNT_W+1)'(cfg.address_bytes);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_ADDR_BYTES; i++) begin
      mask[8*i +: 8] = ((CNT_W+1)'(i) < aw) ? 8'hFF : 8'h00;
    end
  end

  assign b        = in_item.data_byte;
  assign cnt_inc  = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign off_inc  = off_r + OFF_W'(1);
  assign skip_dec = skip_r - {15'd0, (skip_r != 16'd0)};

  // The first byte of a field clears whatever the field register held.
  assign field_base = (cnt_r == '0) ? '0 : ((phase_r == PH_LOW) ? low_r : high_r);
  assign field_sh   = cfg.big_endian ?
                      {field_base[RAW_W-9:0], b} :
                      (field_base | (RAW_W'(b) << {cnt_r, 3'b000}));

  assign len_base = (cnt_r == '0) ? 16'd0 : len_r;
  assign len_sh   = cfg.big_endian ? {len_base[7:0], b} :
                    (cnt_r[0] ? (len_base | {b, 8'h00}) : (len_base | {8'h00, b}));

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    base_nxt  = base_r;
    len_nxt   = len_r;
    skip_nxt  = skip_r;
    off_nxt   = off_r;
    fin_nxt   = fin_r;
    res_valid = 1'b0;
    res_item  = '0;
    res_item.status = ST_TRUNC;

    if (accept) begin
      if (fin_r) begin
        // Waiting for the end of the buffer after a result.
      end else if (off_r >= OFF_W'(MAX_LIST_BYTES)) begin
        res_valid = 1'b1;
        fin_nxt   = 1'b1;
      end else begin
        off_nxt = off_inc;
        case (phase_r)
          PH_LOW, PH_HIGH: begin
            if (phase_r == PH_LOW) begin
              low_nxt = field_sh;
            end else begin
              high_nxt = field_sh;
            end
            if (cnt_inc >= aw) begin
              cnt_nxt = '0;
              if (phase_r == PH_LOW) begin
                phase_nxt = PH_HIGH;
              end else if (low_r == '0 && field_sh == '0) begin
                res_valid       = 1'b1;
                res_item.status = ST_END;
                fin_nxt         = 1'b1;
              end else if ((low_r & mask) == mask) begin
                base_nxt  = 64'(field_sh);
                phase_nxt = PH_LOW;
              end else begin
                lo_nxt    = 64'(low_r) + base_r;
                hi_nxt    = 64'(field_sh) + base_r;
                len_nxt   = 16'd0;
                phase_nxt = PH_LEN;
              end
            end else begin
              cnt_nxt = cnt_inc[CNT_W-1:0];
            end
          end
          PH_LEN: begin
            len_nxt = len_sh;
            if (cnt_inc >= (CNT_W+1)'(LEN_BYTES)) begin
              cnt_nxt = '0;
              if (cfg.query_pc >= lo_r && cfg.query_pc < hi_r) begin
                res_valid            = 1'b1;
                res_item.status      = ST_MATCH;
                res_item.expr_offset = 16'(off_inc);
                res_item.expr_length = len_sh;
                res_item.range_low   = lo_r;
                res_item.range_high  = hi_r;
                fin_nxt              = 1'b1;
              end else if (len_sh == 16'd0) begin
                phase_nxt = PH_LOW;
              end else begin
                skip_nxt  = len_sh;
                phase_nxt = PH_SKIP;
              end
            end else begin
              cnt_nxt = cnt_inc[CNT_W-1:0];
            end
          end
          default: begin
            skip_nxt = skip_dec;
            if (skip_dec == 16'd0) begin
              phase_nxt = PH_LOW;
            end
          end
        endcase
      end

      // The last byte ends the list; report truncation if nothing came out yet.
      if (in_item.last_byte) begin
        if (!fin_nxt) begin
          res_valid = 1'b1;
        end
        phase_nxt = PH_LOW;
        cnt_nxt   = '0;
        base_nxt  = cfg.start_base;
        off_nxt   = '0;
        fin_nxt   = 1'b0;
      end
    end else if (base_wr.load && off_r == '0 && !fin_r) begin
      base_nxt = base_wr.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LOW;
      cnt_r   <= '0;
      base_r  <= '0;
      off_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      base_r  <= base_nxt;
      off_r   <= off_nxt;
      fin_r   <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    high_r <= high_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    len_r  <= len_nxt;
    skip_r <= skip_nxt;
  end

endmodule

// ===== hdl/llrs_skid.sv =====
// Two-entry result buffer: output register plus skid register.
module llrs_skid (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_valid,
  input  llrs_pkg::out_item_t  push_item,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output llrs_pkg::out_item_t  out_item
);
  import llrs_pkg::*;

  logic      head_v_r, head_v_nxt;
  logic      skid_v_r, skid_v_nxt;
  out_item_t head_r, head_nxt;
  out_item_t skid_r, skid_nxt;
  logic      pop;

  assign pop = head_v_r && out_ready;

  always_comb begin
    head_v_nxt = head_v_r;
    skid_v_nxt = skid_v_r;
    head_nxt   = head_r;
    skid_nxt   = skid_r;
    if (pop) begin
      head_nxt   = skid_r;
      head_v_nxt = skid_v_r;
      skid_v_nxt = 1'b0;
    end
    // A push only happens while the skid slot is free.
    if (push_valid) begin
      if (!head_v_nxt) begin
        head_nxt   = push_item;
        head_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_item;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign out_item  = head_r;

endmodule

// ===== test/location_list_range_scanner_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the location list range scanner with its own scan predictor.
module location_list_range_scanner_tb;
  import llrs_pkg::*;

  localparam int MAX_LIST_BYTES = 65536;
  localparam int MAX_ADDR_BYTES = 8;
  localparam int RANDOM_BYTES   = 450;
  localparam int RECONFIG_ROW   = 9;

  localparam bit [3:0] ALL_REGS     = 4'hF;
  localparam bit [3:0] MIDLIST_REGS = (4'b1 << REG_START_BASE) | (4'b1 << REG_ADDRESS_BYTES);

  localparam out_item_t NO_RESULT    = '0;
  localparam out_item_t TRUNC_RESULT = '{ST_TRUNC, 16'd0, 16'd0, 64'd0, 64'd0};
  localparam out_item_t END_RESULT   = '{ST_END, 16'd0, 16'd0, 64'd0, 64'd0};

  localparam logic [3:0] WIDTH_SWEEP [4] = '{4'd0, 4'd8, 4'd15, 4'd1};

  typedef enum logic [1:0] {SCAN_LOW, SCAN_HIGH, SCAN_LEN, SCAN_SKIP} scan_phase_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  // Rows up to the reconfiguration run with the reset settings; the rest use a
  // 2-byte big-endian layout with a query of 0x1008.
  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{'{8'hFF, 1'b1}, 1'b1, TRUNC_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b1}, 1'b1, END_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'hFF, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h10, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h01, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h02, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h10, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h00, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h05, 1'b0}, 1'b0, NO_RESULT},
    '{'{8'h7E, 1'b1}, 1'b0, NO_RESULT}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Predictor state: configuration copy and the list parser.
  cfg_regs_t   model_cfg;
  scan_phase_t scan_phase;
  logic [3:0]  field_cnt;
  logic [63:0] low_acc;
  logic [63:0] high_acc;
  logic [63:0] cur_base;
  logic [15:0] len_acc;
  logic [15:0] skip_left;
  logic [16:0] list_off;
  bit          list_done;

  out_item_t pending_results[$];
  in_item_t  stream_q[$];
  int        mismatch_count;
  int        results_seen;
  bit        in_idle_on;
  bit        out_idle_on;

  location_list_range_scanner #(
    .MAX_LIST_BYTES(MAX_LIST_BYTES),
    .MAX_ADDR_BYTES(MAX_ADDR_BYTES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("location_list_range_scanner: mismatch");
    $finish;
  end

  function automatic int eff_width(logic [3:0] ab);
    int w;
    w = int'(ab);
    if (w < 1) w = 1;
    if (w > MAX_ADDR_BYTES) w = MAX_ADDR_BYTES;
    return w;
  endfunction

  function automatic logic [63:0] lane_mask(int w);
    return (w >= 8) ? '1 : ((64'd1 << (8 * w)) - 64'd1);
  endfunction

  function automatic logic [63:0] shift_in_byte(logic [63:0] acc, logic [7:0] b,
                                                logic [3:0] pos);
    int sh;
    sh = (8 * pos) % 64;
    if (model_cfg.big_endian) return {acc[55:0], b};
    return acc | ({56'd0, b} << sh);
  endfunction

  function automatic void restart_scan();
    scan_phase = SCAN_LOW;
    field_cnt  = '0;
    low_acc    = '0;
    high_acc   = '0;
    cur_base   = model_cfg.start_base;
    len_acc    = '0;
    skip_left  = '0;
    list_off   = '0;
    list_done  = 1'b0;
  endfunction

  function automatic void apply_reg(cfg_idx_t idx, logic [63:0] v);
    case (idx)
      REG_QUERY_PC: model_cfg.query_pc = v;
      REG_START_BASE: begin
        model_cfg.start_base = v;
        if (list_off == 0 && !list_done) cur_base = v;
      end
      REG_ADDRESS_BYTES: model_cfg.address_bytes = v[3:0];
      REG_BIG_ENDIAN: model_cfg.big_endian = v[0];
      default: ;
    endcase
  endfunction

  // Advances the parser by one list byte; returns 1 when the byte yields a result.
  function automatic bit scan_byte(input in_item_t it, output out_item_t res);
    int          w;
    logic [63:0] mask;
    bit          hit;
    res = '0;
    hit = 1'b0;
    if (list_done) begin
      if (it.last_byte) restart_scan();
      return 1'b0;
    end
    if (list_off >= MAX_LIST_BYTES) begin
      res.status = ST_TRUNC;
      list_done = 1'b1;
      if (it.last_byte) restart_scan();
      return 1'b1;
    end
    list_off = list_off + 17'd1;
    w = eff_width(model_cfg.address_bytes);
    case (scan_phase)
      SCAN_LOW, SCAN_HIGH: begin
        if (scan_phase == SCAN_LOW) begin
          if (field_cnt == 0) low_acc = '0;
          low_acc = shift_in_byte(low_acc, it.data_byte, field_cnt);
        end else begin
          if (field_cnt == 0) high_acc = '0;
          high_acc = shift_in_byte(high_acc, it.data_byte, field_cnt);
        end
        field_cnt = field_cnt + 4'd1;
        if (field_cnt >= w) begin
          field_cnt = '0;
          if (scan_phase == SCAN_LOW) begin
            scan_phase = SCAN_HIGH;
          end else begin
            mask = lane_mask(w);
            if (low_acc == 0 && high_acc == 0) begin
              res.status = ST_END;
              hit = 1'b1;
              list_done = 1'b1;
            end else if ((low_acc & mask) == mask) begin
              cur_base = high_acc;
              scan_phase = SCAN_LOW;
            end else begin
              low_acc = low_acc + cur_base;
              high_acc = high_acc + cur_base;
              len_acc = '0;
              scan_phase = SCAN_LEN;
            end
          end
        end
      end
      SCAN_LEN: begin
        if (field_cnt == 0) len_acc = '0;
        len_acc = 16'(shift_in_byte({48'd0, len_acc}, it.data_byte, field_cnt));
        field_cnt = field_cnt + 4'd1;
        if (field_cnt >= LEN_BYTES) begin
          field_cnt = '0;
          if (model_cfg.query_pc >= low_acc && model_cfg.query_pc < high_acc) begin
            res = '{ST_MATCH, list_off[15:0], len_acc, low_acc, high_acc};
            hit = 1'b1;
            list_done = 1'b1;
          end else if (len_acc == 0) begin
            scan_phase = SCAN_LOW;
          end else begin
            skip_left = len_acc;
            scan_phase = SCAN_SKIP;
          end
        end
      end
      default: begin
        if (skip_left > 0) skip_left = skip_left - 16'd1;
        if (skip_left == 0) scan_phase = SCAN_LOW;
      end
    endcase
    if (it.last_byte) begin
      if (!list_done) begin
        res = TRUNC_RESULT;
        hit = 1'b1;
      end
      restart_scan();
    end
    return hit;
  endfunction

  task automatic send_byte(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t res;
    bit        got;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = scan_byte(it, res);
    if (typed) pending_results.push_back(want);
    else if (got) pending_results.push_back(res);
  endtask

  task automatic send_span(input int from, input int upto);
    for (int i = from; i < upto; i++) send_byte(stream_q[i], 1'b0, NO_RESULT);
  endtask

  // Lets the block go idle: every expected result out, then a few spare cycles.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input cfg_regs_t r, input bit [3:0] sel);
    cfg_idx_t    idx;
    logic [63:0] v;
    idx = idx.first();
    repeat (idx.num()) begin
      if (sel[idx]) begin
        v = {$urandom, $urandom};
        case (idx)
          REG_QUERY_PC:      v = r.query_pc;
          REG_START_BASE:    v = r.start_base;
          REG_ADDRESS_BYTES: v[3:0] = r.address_bytes;
          default:           v[0] = r.big_endian;
        endcase
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge clk);
        apply_reg(idx, v);
      end
      idx = idx.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic put_field(input logic [63:0] v, input int nbytes, input bit big);
    logic [7:0] b;
    for (int i = 0; i < nbytes; i++) begin
      b = big ? v[8 * (nbytes - 1 - i) +: 8] : v[8 * i +: 8];
      stream_q.push_back({b, 1'b0});
    end
  endtask

  task automatic put_random(input int n);
    repeat (n) stream_q.push_back({8'($urandom), 1'b0});
  endtask

  task automatic mark_last();
    in_item_t tail;
    tail = stream_q.pop_back();
    tail.last_byte = 1'b1;
    stream_q.push_back(tail);
  endtask

  // One list: base selections, entries aimed at the query and random ones, usually an
  // end-of-list entry, then either cut short or followed by a few trailing bytes.
  task automatic build_list(input int w, input bit big, input logic [63:0] query,
                            input logic [63:0] base);
    int          start;
    int          cut;
    int          kind;
    int          d;
    logic [63:0] mask;
    logic [63:0] lo_raw;
    logic [63:0] hi_raw;
    logic [63:0] cur;
    logic [15:0] len;
    start = stream_q.size();
    mask  = lane_mask(w);
    cur   = base;
    repeat ($urandom_range(0, 4)) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        hi_raw = {$urandom, $urandom} & mask;
        put_field(mask, w, big);
        put_field(hi_raw, w, big);
        cur = hi_raw;
      end else begin
        if (kind < 6) begin
          d = $urandom_range(0, 3);
          lo_raw = (query - cur - 64'(d)) & mask;
          hi_raw = (lo_raw + 64'(d + 1 + $urandom_range(0, 3))) & mask;
        end else begin
          lo_raw = {$urandom, $urandom} & mask;
          hi_raw = {$urandom, $urandom} & mask;
        end
        len = 16'($urandom_range(0, 4));
        put_field(lo_raw, w, big);
        put_field(hi_raw, w, big);
        put_field({48'd0, len}, LEN_BYTES, big);
        put_random(len);
      end
    end
    if ($urandom_range(0, 3) != 0) begin
      put_field('0, w, big);
      put_field('0, w, big);
    end
    if ($urandom_range(0, 4) == 0 && stream_q.size() > start + 1) begin
      cut = $urandom_range(start + 1, stream_q.size());
      while (stream_q.size() > cut) void'(stream_q.pop_back());
    end else begin
      put_random($urandom_range(0, 3));
    end
    if (stream_q.size() == start) put_random(1);
    mark_last();
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen = results_seen + 1;
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("result %0d unexpected: status %0d off %h len %h range %h..%h",
                   results_seen, out_item.status, out_item.expr_offset,
                   out_item.expr_length, out_item.range_low, out_item.range_high);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status || out_item.expr_offset !== want.expr_offset ||
            out_item.expr_length !== want.expr_length ||
            out_item.range_low !== want.range_low ||
            out_item.range_high !== want.range_high) begin
          if (mismatch_count < 10)
            $display({"result %0d wrong: expected status %0d off %h len %h range %h..%h,",
                      " got status %0d off %h len %h range %h..%h"},
                     results_seen, want.status, want.expr_offset, want.expr_length,
                     want.range_low, want.range_high, out_item.status,
                     out_item.expr_offset, out_item.expr_length, out_item.range_low,
                     out_item.range_high);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  initial begin : ready_driver
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    cfg_regs_t   grp_cfg;
    cfg_regs_t   mid_cfg;
    int          group;
    int          random_sent;
    int          split;
    int          w;
    logic [63:0] mask;

    mismatch_count = 0;
    results_seen   = 0;
    in_idle_on     = 1'b0;
    out_idle_on    = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_ready <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_QUERY_PC;
    cfg_wdata <= '0;
    model_cfg = '{query_pc: '0, start_base: '0, address_bytes: ADDR_BYTES_RESET,
                  big_endian: 1'b0};
    restart_scan();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      if (i == RECONFIG_ROW) begin
        settle();
        program_regs('{query_pc: 64'h1008, start_base: '0, address_bytes: 4'd2,
                       big_endian: 1'b1}, ALL_REGS);
      end
      send_byte(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    // Random lists, a few per configuration; some groups rewrite the width and start base mid-list.
    group = 0;
    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      grp_cfg.address_bytes = (group < 4) ? WIDTH_SWEEP[group] : 4'($urandom_range(0, 15));
      grp_cfg.big_endian = (group < 2) ? group[0] : 1'($urandom_range(0, 1));
      w = eff_width(grp_cfg.address_bytes);
      mask = lane_mask(w);
      if (group == 0) grp_cfg.start_base = '0;
      else if (group == 2) grp_cfg.start_base = '1;
      else if ($urandom_range(0, 1) == 0) grp_cfg.start_base = {$urandom, $urandom};
      else grp_cfg.start_base = 64'($urandom_range(0, 255));
      if (group == 0) grp_cfg.query_pc = '0;
      else if (group == 1) grp_cfg.query_pc = '1;
      else if ($urandom_range(0, 1) == 0) grp_cfg.query_pc = {$urandom, $urandom};
      else grp_cfg.query_pc = {$urandom, $urandom} & mask;
      settle();
      program_regs(grp_cfg, ALL_REGS);
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      stream_q.delete();
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 7) == 0) begin
          put_random($urandom_range(1, 12));
          mark_last();
        end else begin
          build_list(w, grp_cfg.big_endian, grp_cfg.query_pc, grp_cfg.start_base);
        end
      end
      split = ($urandom_range(0, 2) == 0) ? stream_q.size() / 2 : stream_q.size();
      send_span(0, split);
      if (split < stream_q.size()) begin
        settle();
        mid_cfg = model_cfg;
        mid_cfg.address_bytes = 4'($urandom_range(0, 15));
        mid_cfg.start_base = {$urandom, $urandom};
        program_regs(mid_cfg, MIDLIST_REGS);
        send_span(split, stream_q.size());
      end
      random_sent = random_sent + stream_q.size();
      group = group + 1;
    end

    // A few more lists at full rate on both sides.
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    settle();
    stream_q.delete();
    repeat (3) build_list(w, grp_cfg.big_endian, grp_cfg.query_pc, grp_cfg.start_base);
    send_span(0, stream_q.size());

    in_valid <= 1'b0;
    for (int k = 0; k < 5000 && pending_results.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    mismatch_count = mismatch_count + pending_results.size();
    if (mismatch_count == 0) begin
      $display("location_list_range_scanner: match");
    end else begin
      $display("location_list_range_scanner: mismatch");
    end
    $finish;
  end

endmodule
